### src/phase_table_lookup_and_stats_core_assert.svh
// Assertion macros shared by the region statistics table modules.
// Define ASSERT_OFF to compile the checks out.
`ifndef PHASE_TABLE_LOOKUP_AND_STATS_CORE_ASSERT_SVH
`define PHASE_TABLE_LOOKUP_AND_STATS_CORE_ASSERT_SVH
`ifndef ASSERT_OFF
// The consequent must hold in the same cycle as the antecedent.
`define PTLS_ASSERT_IMP(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("ptls assertion failed");
// The consequent must hold in the cycle after the antecedent.
`define PTLS_ASSERT_NXT(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("ptls assertion failed");
`else
`define PTLS_ASSERT_IMP(lbl, clk, rst_n, ante, cons)
`define PTLS_ASSERT_NXT(lbl, clk, rst_n, ante, cons)
`endif
`endif

### src/ptls_pkg.sv
package ptls_pkg;

    // Table geometry.
    localparam int ENTRIES = 64;
    localparam int IDX_W   = $clog2(ENTRIES);
    localparam int CNT_W   = $clog2(ENTRIES + 1);

    // Operation codes.
    localparam logic [1:0] OP_FIND   = 2'd0;
    localparam logic [1:0] OP_RECORD = 2'd1;
    localparam logic [1:0] OP_READ   = 2'd2;

    // Result status codes.
    localparam logic [1:0] ST_OK     = 2'd0;
    localparam logic [1:0] ST_FULL   = 2'd1;
    localparam logic [1:0] ST_UNUSED = 2'd2;

    typedef struct packed {
        logic [15:0] from_file;
        logic [19:0] from_line;
        logic [15:0] to_file;
        logic [19:0] to_line;
    } t_key;

    typedef struct packed {
        logic [31:0] count;
        logic [63:0] sum;
        logic [31:0] len_max;
        logic [31:0] len_min;
    } t_stats;

    typedef struct packed {
        logic [1:0]       operation;
        t_key             key;
        logic [IDX_W-1:0] entry_index;
        logic [31:0]      length;
    } t_item;

    typedef struct packed {
        logic [IDX_W-1:0] result_index;
        logic             is_new;
        logic [1:0]       status;
        t_stats           stats;
    } t_result;

    // Commands from the controller to the datapath.
    typedef struct packed {
        logic capture;
        logic scan_step;
        logic found;
        logic insert;
        logic set_full;
        logic stat_rd;
        logic set_unused;
        logic load_out;
    } t_cmd;

    // Status from the datapath to the controller.
    typedef struct packed {
        logic op_find;
        logic hit;
        logic scan_more;
        logic tbl_full;
        logic idx_used;
        logic out_free;
    } t_sts;

endpackage

### src/ptls_if.sv
// Request channel: one operation on the table per transfer.
interface ptls_in_if;
    import ptls_pkg::*;

    logic             valid;
    logic             ready;
    logic [1:0]       operation;
    logic [15:0]      from_file;
    logic [19:0]      from_line;
    logic [15:0]      to_file;
    logic [19:0]      to_line;
    logic [IDX_W-1:0] entry_index;
    logic [31:0]      length;

    modport source (
        output valid, operation, from_file, from_line, to_file, to_line,
               entry_index, length,
        input  ready
    );
    modport sink (
        input  valid, operation, from_file, from_line, to_file, to_line,
               entry_index, length,
        output ready
    );
endinterface

// Result channel: one result per request.
interface ptls_out_if;
    import ptls_pkg::*;

    logic             valid;
    logic             ready;
    logic [IDX_W-1:0] result_index;
    logic             is_new;
    logic [1:0]       status;
    logic [31:0]      hit_count;
    logic [63:0]      length_sum;
    logic [31:0]      length_max;
    logic [31:0]      length_min;

    modport source (
        output valid, result_index, is_new, status, hit_count, length_sum,
               length_max, length_min,
        input  ready
    );
    modport sink (
        input  valid, result_index, is_new, status, hit_count, length_sum,
               length_max, length_min,
        output ready
    );
endinterface

### src/ptls_ram.sv
module ptls_ram #(
    parameter int  WIDTH = 8,
    parameter int  DEPTH = 64,
    localparam int AW    = $clog2(DEPTH)
) (
    input  logic             i_clk,
    input  logic             i_we,
    input  logic [AW-1:0]    i_waddr,
    input  logic [WIDTH-1:0] i_wdata,
    input  logic             i_re,
    input  logic [AW-1:0]    i_raddr,
    output logic [WIDTH-1:0] o_rdata
);
    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    // One write port and one registered read port; read data holds when idle.
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;
endmodule

### src/ptls_dp.sv
`include "phase_table_lookup_and_stats_core_assert.svh"

module ptls_dp (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  ptls_pkg::t_cmd    i_cmd,
    input  ptls_pkg::t_item   i_item,
    input  logic              i_out_ready,
    output ptls_pkg::t_sts    o_sts,
    output logic              o_out_valid,
    output ptls_pkg::t_result o_out
);
    import ptls_pkg::*;

    t_item            r_item;
    logic [CNT_W-1:0] r_idx;
    logic             r_cmp_valid;
    logic [IDX_W-1:0] r_cmp_idx;
    logic [CNT_W-1:0] r_used;
    logic [IDX_W-1:0] r_res_idx;
    logic             r_res_new;
    logic [1:0]       r_res_status;
    logic             r_use_stats;
    logic             r_do_update;
    logic             r_out_valid;
    t_result          r_out;

    t_key             key_rdata;
    t_stats           stats_rdata;
    t_stats           upd_stats;
    t_stats           res_stats;
    logic             key_match;
    logic             stats_we;
    logic [IDX_W-1:0] stats_waddr;
    t_stats           stats_wdata;
    logic [IDX_W-1:0] stats_raddr;

    // Key store: read one entry per scan step, written when a new entry is taken.
    ptls_ram #(.WIDTH($bits(t_key)), .DEPTH(ENTRIES)) u_key_ram (
        .i_clk   (i_clk),
        .i_we    (i_cmd.insert),
        .i_waddr (r_used[IDX_W-1:0]),
        .i_wdata (r_item.key),
        .i_re    (i_cmd.scan_step),
        .i_raddr (r_idx[IDX_W-1:0]),
        .o_rdata (key_rdata)
    );

    // Statistics store: cleared on insert, rewritten when a record result leaves.
    assign stats_we    = i_cmd.insert | (i_cmd.load_out & r_do_update);
    assign stats_waddr = i_cmd.insert ? r_used[IDX_W-1:0] : r_res_idx;
    assign stats_wdata = i_cmd.insert ? '0 : upd_stats;
    assign stats_raddr = i_cmd.found ? r_cmp_idx : r_item.entry_index;

    ptls_ram #(.WIDTH($bits(t_stats)), .DEPTH(ENTRIES)) u_stats_ram (
        .i_clk   (i_clk),
        .i_we    (stats_we),
        .i_waddr (stats_waddr),
        .i_wdata (stats_wdata),
        .i_re    (i_cmd.found | i_cmd.stat_rd),
        .i_raddr (stats_raddr),
        .o_rdata (stats_rdata)
    );

    // Record update: saturating count, wrapping sum, running maximum and minimum.
    always_comb begin
        upd_stats.count   = (stats_rdata.count == '1) ? stats_rdata.count
                                                      : stats_rdata.count + 32'd1;
        upd_stats.sum     = stats_rdata.sum + {32'd0, r_item.length};
        upd_stats.len_max = (r_item.length > stats_rdata.len_max) ? r_item.length
                                                                  : stats_rdata.len_max;
        upd_stats.len_min = (stats_rdata.len_min == 32'd0 ||
                             r_item.length < stats_rdata.len_min) ? r_item.length
                                                                  : stats_rdata.len_min;
    end

    always_comb begin
        if (!r_use_stats) begin
            res_stats = '0;
        end else if (r_do_update) begin
            res_stats = upd_stats;
        end else begin
            res_stats = stats_rdata;
        end
    end

    assign key_match = (key_rdata == r_item.key);

    // Status towards the controller.
    assign o_sts.op_find   = (r_item.operation == OP_FIND);
    assign o_sts.hit       = r_cmp_valid & key_match;
    assign o_sts.scan_more = (r_idx < r_used);
    assign o_sts.tbl_full  = (r_used == CNT_W'(ENTRIES));
    assign o_sts.idx_used  = (CNT_W'(r_item.entry_index) < r_used);
    assign o_sts.out_free  = !r_out_valid || i_out_ready;

    // Request register.
    always_ff @(posedge i_clk) begin
        if (i_cmd.capture) begin
            r_item <= i_item;
        end
    end

    // Scan pointer and compare stage.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_idx       <= '0;
            r_cmp_valid <= 1'b0;
            r_cmp_idx   <= '0;
        end else if (i_cmd.capture) begin
            r_idx       <= '0;
            r_cmp_valid <= 1'b0;
        end else if (i_cmd.scan_step) begin
            r_idx       <= r_idx + CNT_W'(1);
            r_cmp_valid <= 1'b1;
            r_cmp_idx   <= r_idx[IDX_W-1:0];
        end
    end

    // Fill count of the table.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_used <= '0;
        end else if (i_cmd.insert) begin
            r_used <= r_used + CNT_W'(1);
        end
    end

    // Result description, registered together with any statistics read.
    always_ff @(posedge i_clk) begin
        if (i_cmd.found) begin
            r_res_idx    <= r_cmp_idx;
            r_res_new    <= 1'b0;
            r_res_status <= ST_OK;
            r_use_stats  <= 1'b1;
            r_do_update  <= 1'b0;
        end else if (i_cmd.stat_rd) begin
            r_res_idx    <= r_item.entry_index;
            r_res_new    <= 1'b0;
            r_res_status <= ST_OK;
            r_use_stats  <= 1'b1;
            r_do_update  <= (r_item.operation == OP_RECORD);
        end else if (i_cmd.set_unused) begin
            r_res_idx    <= r_item.entry_index;
            r_res_new    <= 1'b0;
            r_res_status <= ST_UNUSED;
            r_use_stats  <= 1'b0;
            r_do_update  <= 1'b0;
        end else if (i_cmd.set_full) begin
            r_res_idx    <= '0;
            r_res_new    <= 1'b0;
            r_res_status <= ST_FULL;
            r_use_stats  <= 1'b0;
            r_do_update  <= 1'b0;
        end else if (i_cmd.insert) begin
            r_res_idx    <= r_used[IDX_W-1:0];
            r_res_new    <= 1'b1;
            r_res_status <= ST_OK;
            r_use_stats  <= 1'b0;
            r_do_update  <= 1'b0;
        end
    end

    // Output register: holds one result until its transfer completes.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (i_cmd.load_out) begin
            r_out_valid <= 1'b1;
        end else if (i_out_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.load_out) begin
            r_out.result_index <= r_res_idx;
            r_out.is_new       <= r_res_new;
            r_out.status       <= r_res_status;
            r_out.stats        <= res_stats;
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_out       = r_out;

    `PTLS_ASSERT_IMP(a_used_bound, i_clk, i_rst_n, 1'b1, r_used <= CNT_W'(ENTRIES))
    `PTLS_ASSERT_IMP(a_insert_room, i_clk, i_rst_n, i_cmd.insert, r_used < CNT_W'(ENTRIES))
    `PTLS_ASSERT_IMP(a_hit_in_use, i_clk, i_rst_n, o_sts.hit, CNT_W'(r_cmp_idx) < r_used)
    `PTLS_ASSERT_IMP(a_load_free, i_clk, i_rst_n, i_cmd.load_out, o_sts.out_free)
endmodule

### src/ptls_ctrl.sv
`include "phase_table_lookup_and_stats_core_assert.svh"

module ptls_ctrl (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_in_valid,
    input  ptls_pkg::t_sts i_sts,
    output logic           o_in_ready,
    output ptls_pkg::t_cmd o_cmd
);
    import ptls_pkg::*;

    typedef enum logic [4:0] {
        S_IDLE     = 5'b00001,
        S_DISPATCH = 5'b00010,
        S_SCAN     = 5'b00100,
        S_STAT     = 5'b01000,
        S_DONE     = 5'b10000
    } t_state;

    t_state r_state;
    t_state n_state;

    // Next state and commands for the datapath.
    always_comb begin
        n_state    = r_state;
        o_cmd      = '0;
        o_in_ready = 1'b0;
        unique case (r_state)
            S_IDLE: begin
                // No request is taken while reset is held.
                o_in_ready = i_rst_n;
                if (i_in_valid && i_rst_n) begin
                    o_cmd.capture = 1'b1;
                    n_state       = S_DISPATCH;
                end
            end
            S_DISPATCH: begin
                priority if (i_sts.op_find) begin
                    n_state = S_SCAN;
                end else if (i_sts.idx_used) begin
                    o_cmd.stat_rd = 1'b1;
                    n_state       = S_STAT;
                end else begin
                    o_cmd.set_unused = 1'b1;
                    n_state          = S_DONE;
                end
            end
            S_SCAN: begin
                priority if (i_sts.hit) begin
                    o_cmd.found = 1'b1;
                    n_state     = S_STAT;
                end else if (i_sts.scan_more) begin
                    o_cmd.scan_step = 1'b1;
                end else if (i_sts.tbl_full) begin
                    o_cmd.set_full = 1'b1;
                    n_state        = S_DONE;
                end else begin
                    o_cmd.insert = 1'b1;
                    n_state      = S_DONE;
                end
            end
            S_STAT: begin
                n_state = S_DONE;
            end
            S_DONE: begin
                if (i_sts.out_free) begin
                    o_cmd.load_out = 1'b1;
                    n_state        = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    `PTLS_ASSERT_NXT(a_done_holds, i_clk, i_rst_n, r_state == S_DONE && !i_sts.out_free,
                     r_state == S_DONE)
    `PTLS_ASSERT_NXT(a_capture_dispatch, i_clk, i_rst_n, o_cmd.capture,
                     r_state == S_DISPATCH)
    `PTLS_ASSERT_NXT(a_stat_then_done, i_clk, i_rst_n, o_cmd.found || o_cmd.stat_rd,
                     r_state == S_STAT)
endmodule

### src/phase_table_lookup_and_stats_core.sv
// Record or read: the request is captured, dispatched, its statistics read in the stat
// state and the result loaded in the done state; an unused entry skips the stat state.
// Find scans keys one per cycle; a hit reads statistics, a miss inserts or reports full.
// Throughput: one request at a time; the next is taken the cycle after the result loads.
// Reset clears the fill count, the controller and the output valid; no clearing pass
// is needed, as entries are zeroed when taken and unused entries are never read.
module phase_table_lookup_and_stats_core (
    input  logic              i_clk,
    input  logic              i_rst_n,
    ptls_in_if.sink           i_in,
    ptls_out_if.source        o_out
);
    import ptls_pkg::*;

    t_cmd    cmd;
    t_sts    sts;
    t_item   item;
    t_result res;
    logic    out_valid;
    logic    in_ready;

    // Gather the request fields into one item.
    assign item.operation     = i_in.operation;
    assign item.key.from_file = i_in.from_file;
    assign item.key.from_line = i_in.from_line;
    assign item.key.to_file   = i_in.to_file;
    assign item.key.to_line   = i_in.to_line;
    assign item.entry_index   = i_in.entry_index;
    assign item.length        = i_in.length;
    assign i_in.ready         = in_ready;

    ptls_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in.valid),
        .i_sts      (sts),
        .o_in_ready (in_ready),
        .o_cmd      (cmd)
    );

    ptls_dp u_dp (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cmd       (cmd),
        .i_item      (item),
        .i_out_ready (o_out.ready),
        .o_sts       (sts),
        .o_out_valid (out_valid),
        .o_out       (res)
    );

    // Spread the result onto the output channel.
    assign o_out.valid        = out_valid;
    assign o_out.result_index = res.result_index;
    assign o_out.is_new       = res.is_new;
    assign o_out.status       = res.status;
    assign o_out.hit_count    = res.stats.count;
    assign o_out.length_sum   = res.stats.sum;
    assign o_out.length_max   = res.stats.len_max;
    assign o_out.length_min   = res.stats.len_min;
endmodule
